// ===== hdl/go_back_n_link_engine_core_macros.svh =====
// ----------------------------------------------------------------------------
// go_back_n_link_engine_core_macros
// Assertion macros shared by the link engine; empty when synthesising.
// ----------------------------------------------------------------------------
`ifndef GO_BACK_N_LINK_ENGINE_CORE_MACROS_SVH
`define GO_BACK_N_LINK_ENGINE_CORE_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define GBN_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("link engine check failed");
// next-cycle implication
`define GBN_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("link engine check failed");
`else
`define GBN_ASSERT_IMP(label, clk, rst, ante, cons)
`define GBN_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== hdl/gbn_pkg.sv =====
// ----------------------------------------------------------------------------
// gbn_pkg
// Types, constants and helpers of the go-back-N link engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package gbn_pkg;

   localparam int MAX_SEQUENCE  = 7;
   localparam int SLOTS         = MAX_SEQUENCE + 1;
   localparam int SEQ_W         = 3;
   localparam int LINK_W        = 3;
   localparam int NODE_W        = 3;
   localparam int NODE_COUNT    = 8;
   localparam int MASK_W        = 8;
   localparam int WCNT_W        = 3;
   localparam int BCNT_W        = 4;
   localparam int GUARD_W       = 4;
   localparam int RESULT_CAP    = 16;
   localparam int RES_IDX_W     = 4;
   localparam int RES_CNT_W     = 5;
   localparam int NUM_LINKS_DEF = 4;
   localparam int TAG_WIDTH_DEF = 32;
   localparam int PORT_TAG_W    = 32;
   localparam int CSR_ADDR_W    = 3;
   localparam int CSR_DATA_W    = 32;

   localparam logic [MASK_W-1:0] ALL_NODES = MASK_W'((1 << NODE_COUNT) - 1);

   // register indexes
   localparam logic ADDR_OWN_NODE  = 1'b0;
   localparam logic ADDR_ROUTE_MAP = 1'b1;

   typedef enum logic [2:0] {
      ACT_NONE    = 3'd0,
      ACT_SEND    = 3'd1,
      ACT_ACK     = 3'd2,
      ACT_DELIVER = 3'd3,
      ACT_STOP    = 3'd4,
      ACT_DROP    = 3'd5,
      ACT_OUTSIDE = 3'd6
   } action_type;

   typedef enum logic [1:0] {
      KIND_SEND    = 2'd0,
      KIND_ARRIVE  = 2'd1,
      KIND_TIMEOUT = 2'd2
   } kind_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_DROP_BAD,
      OP_DROP_FULL,
      OP_ENQ,
      OP_DATA_ACK,
      OP_DELIVER,
      OP_DUP_ACK,
      OP_TO_READ,
      OP_TO_EMIT,
      OP_ACK_OUT,
      OP_ACK_STEP,
      OP_REF_READ,
      OP_REF_WRITE,
      OP_FINISH,
      OP_DRAIN_READ,
      OP_DRAIN_LOAD
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic [1:0] kind;
      logic       link_ok;
      logic       frame_ok;
      logic       is_ack;
      logic       seq_ok;
      logic       route_bad;
      logic       room;
      logic       seq_is_fe;
      logic       seq_is_dup;
      logic       dest_own;
      logic       in_window;
      logic       guard_ok;
      logic       refill_ok;
      logic       out_free;
      logic       drain_done;
   } status_type;

   function automatic logic [SEQ_W-1:0] seq_inc(input logic [SEQ_W-1:0] v);
      return (v >= SEQ_W'(MAX_SEQUENCE)) ? '0 : v + SEQ_W'(1);
   endfunction

   function automatic logic seq_between(input logic [SEQ_W-1:0] lo,
                                        input logic [SEQ_W-1:0] num,
                                        input logic [SEQ_W-1:0] up);
      return (lo <= num && num < up) || (up < lo && lo <= num) || (num < up && up < lo);
   endfunction

endpackage

// ===== hdl/gbn_ctrl.sv =====
// ----------------------------------------------------------------------------
// gbn_ctrl
// Sequencer of the link engine: walks each item through its datapath steps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module gbn_ctrl
   import gbn_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type stat,
   output cmd_type    cmd
);

   typedef enum logic [10:0] {
      ST_IDLE      = 11'b000_0000_0001,
      ST_DISPATCH  = 11'b000_0000_0010,
      ST_DELIVER   = 11'b000_0000_0100,
      ST_ENQ       = 11'b000_0000_1000,
      ST_TO_WAIT   = 11'b000_0001_0000,
      ST_ACK_LOOP  = 11'b000_0010_0000,
      ST_REFILL    = 11'b000_0100_0000,
      ST_REFILL_WR = 11'b000_1000_0000,
      ST_FINISH    = 11'b001_0000_0000,
      ST_DRAIN_RD  = 11'b010_0000_0000,
      ST_DRAIN_LD  = 11'b100_0000_0000
   } state_type;

   state_type state_ff, state_in;

   assign req_stall = (state_ff != ST_IDLE);

   // next state and datapath command
   always_comb begin
      state_in = state_ff;
      cmd.op   = OP_NONE;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            state_in = ST_FINISH;
            if (stat.kind == KIND_SEND) begin
               if (stat.route_bad) begin
                  cmd.op = OP_DROP_BAD;
               end else if (stat.room) begin
                  cmd.op = OP_ENQ;
               end else begin
                  cmd.op = OP_DROP_FULL;
               end
            end else if (stat.kind == KIND_ARRIVE && stat.link_ok && stat.frame_ok) begin
               if (stat.is_ack) begin
                  if (stat.in_window) begin
                     state_in = ST_ACK_LOOP;
                  end else begin
                     cmd.op   = OP_ACK_OUT;
                     state_in = ST_REFILL;
                  end
               end else if (stat.seq_is_fe) begin
                  if (stat.dest_own) begin
                     cmd.op   = OP_DATA_ACK;
                     state_in = ST_DELIVER;
                  end else if (stat.route_bad) begin
                     cmd.op = OP_DROP_BAD;
                  end else if (stat.room) begin
                     cmd.op   = OP_DATA_ACK;
                     state_in = ST_ENQ;
                  end else begin
                     cmd.op = OP_DROP_FULL;
                  end
               end else if (stat.seq_is_dup) begin
                  cmd.op = OP_DUP_ACK;
               end
            end else if (stat.kind == KIND_TIMEOUT && stat.link_ok && stat.seq_ok) begin
               cmd.op   = OP_TO_READ;
               state_in = ST_TO_WAIT;
            end
         end
         ST_DELIVER: begin
            cmd.op   = OP_DELIVER;
            state_in = ST_FINISH;
         end
         ST_ENQ: begin
            cmd.op   = OP_ENQ;
            state_in = ST_FINISH;
         end
         ST_TO_WAIT: begin
            cmd.op   = OP_TO_EMIT;
            state_in = ST_FINISH;
         end
         ST_ACK_LOOP: begin
            if (stat.guard_ok && stat.in_window) begin
               cmd.op = OP_ACK_STEP;
            end else begin
               state_in = ST_REFILL;
            end
         end
         ST_REFILL: begin
            if (stat.refill_ok) begin
               cmd.op   = OP_REF_READ;
               state_in = ST_REFILL_WR;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_REFILL_WR: begin
            cmd.op   = OP_REF_WRITE;
            state_in = ST_REFILL;
         end
         ST_FINISH: begin
            cmd.op   = OP_FINISH;
            state_in = ST_DRAIN_RD;
         end
         ST_DRAIN_RD: begin
            if (stat.drain_done) begin
               state_in = ST_IDLE;
            end else begin
               cmd.op   = OP_DRAIN_READ;
               state_in = ST_DRAIN_LD;
            end
         end
         ST_DRAIN_LD: begin
            if (stat.out_free) begin
               cmd.op   = OP_DRAIN_LOAD;
               state_in = ST_DRAIN_RD;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hdl/gbn_datapath.sv =====
// ----------------------------------------------------------------------------
// gbn_datapath
// Per-link sequence state, window and overflow stores, result buffer,
// output register and configuration registers of the link engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module gbn_datapath
   import gbn_pkg::*;
#(
   parameter int NUM_LINKS = NUM_LINKS_DEF,
   parameter int TAG_WIDTH = TAG_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output status_type            stat,
   // item in
   input  logic [1:0]            req_kind,
   input  logic [LINK_W-1:0]     req_link,
   input  logic                  req_is_ack,
   input  logic                  req_check_ok,
   input  logic [SEQ_W-1:0]      req_seq,
   input  logic [NODE_W-1:0]     req_src_node,
   input  logic [NODE_W-1:0]     req_dest_node,
   input  logic [PORT_TAG_W-1:0] req_payload_tag,
   // result out
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [2:0]            rsp_action,
   output logic [LINK_W-1:0]     rsp_out_link,
   output logic [SEQ_W-1:0]      rsp_out_seq,
   output logic [NODE_W-1:0]     rsp_out_src,
   output logic [NODE_W-1:0]     rsp_out_dest,
   output logic [PORT_TAG_W-1:0] rsp_out_tag,
   output logic [MASK_W-1:0]     rsp_dest_enable,
   output logic                  rsp_last,
   // configuration
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata
);

   localparam int LI_W      = (NUM_LINKS > 1) ? $clog2(NUM_LINKS) : 1;
   localparam int ADDR_W    = LI_W + SEQ_W;
   localparam int MEM_DEPTH = NUM_LINKS * SLOTS;
   localparam int ENTRY_W   = 2 * NODE_W + TAG_WIDTH;
   localparam int RES_W     = 3 + LINK_W + SEQ_W + 2 * NODE_W + TAG_WIDTH;
   // record field positions
   localparam int R_ACT  = RES_W - 3;
   localparam int R_LINK = R_ACT - LINK_W;
   localparam int R_SEQ  = R_LINK - SEQ_W;
   localparam int R_SRC  = R_SEQ - NODE_W;
   localparam int R_DEST = R_SRC - NODE_W;

   // configuration
   logic [NODE_W-1:0]      own_node_ff;
   logic [3*NODE_COUNT-1:0] route_map_ff;

   // item registers
   logic [1:0]           kind_ff;
   logic [LINK_W-1:0]    link_ff;
   logic                 is_ack_ff;
   logic                 ok_ff;
   logic [SEQ_W-1:0]     seq_ff;
   logic [NODE_W-1:0]    src_ff;
   logic [NODE_W-1:0]    dest_ff;
   logic [TAG_WIDTH-1:0] tag_ff;

   // per-link state
   logic [SEQ_W-1:0]  nts_ff [NUM_LINKS];
   logic [SEQ_W-1:0]  nts_in [NUM_LINKS];
   logic [SEQ_W-1:0]  ae_ff  [NUM_LINKS];
   logic [SEQ_W-1:0]  ae_in  [NUM_LINKS];
   logic [SEQ_W-1:0]  fe_ff  [NUM_LINKS];
   logic [SEQ_W-1:0]  fe_in  [NUM_LINKS];
   logic [WCNT_W-1:0] wc_ff  [NUM_LINKS];
   logic [WCNT_W-1:0] wc_in  [NUM_LINKS];
   logic [SEQ_W-1:0]  hd_ff  [NUM_LINKS];
   logic [SEQ_W-1:0]  hd_in  [NUM_LINKS];
   logic [SEQ_W-1:0]  tl_ff  [NUM_LINKS];
   logic [SEQ_W-1:0]  tl_in  [NUM_LINKS];
   logic [BCNT_W-1:0] bc_ff  [NUM_LINKS];
   logic [BCNT_W-1:0] bc_in  [NUM_LINKS];
   logic [MASK_W-1:0] mask_ff, mask_in;

   // item bookkeeping
   logic [GUARD_W-1:0]   guard_ff, guard_in;
   logic                 chk_ff, chk_in;
   logic [LINK_W-1:0]    chk_link_ff, chk_link_in;
   logic [RES_CNT_W-1:0] res_cnt_ff, res_cnt_in;
   logic [RES_CNT_W-1:0] drain_idx_ff;

   // stores
   logic [ENTRY_W-1:0] win_mem_ff [MEM_DEPTH];
   logic [ENTRY_W-1:0] buf_mem_ff [MEM_DEPTH];
   logic [RES_W-1:0]   res_mem_ff [RESULT_CAP];
   logic [ENTRY_W-1:0] win_rdata_ff;
   logic [ENTRY_W-1:0] buf_rdata_ff;
   logic [RES_W-1:0]   res_rdata_ff;

   logic               win_we, buf_we, win_re, buf_re;
   logic [ADDR_W-1:0]  win_waddr, buf_waddr, win_raddr, buf_raddr;
   logic [ENTRY_W-1:0] win_wdata, buf_wdata;

   // emitted record
   logic                 emit_en;
   action_type           e_act;
   logic [LINK_W-1:0]    e_link;
   logic [SEQ_W-1:0]     e_seq;
   logic [NODE_W-1:0]    e_src;
   logic [NODE_W-1:0]    e_dest;
   logic [TAG_WIDTH-1:0] e_tag;

   // output register
   logic             rsp_valid_ff;
   logic [RES_W-1:0] rsp_rec_ff;
   logic [MASK_W-1:0] rsp_mask_ff;
   logic             rsp_last_ff;

   // derived item values
   logic [LI_W-1:0]   link_li, route_li, chk_li;
   logic [LINK_W-1:0] ol;
   logic [SEQ_W-1:0]  fe_cur, dup_seq;
   logic              ack_item, links_clear;
   logic [ENTRY_W-1:0] item_entry;

   assign link_li    = LI_W'(link_ff - LINK_W'(1));
   assign ol         = route_map_ff[3*dest_ff +: 3];
   assign route_li   = LI_W'(ol - LINK_W'(1));
   assign chk_li     = LI_W'(chk_link_ff - LINK_W'(1));
   assign fe_cur     = fe_ff[link_li];
   assign dup_seq    = (fe_cur == '0) ? SEQ_W'(MAX_SEQUENCE) : fe_cur - SEQ_W'(1);
   assign item_entry = {src_ff, dest_ff, tag_ff};
   assign ack_item   = (kind_ff == KIND_ARRIVE) && stat.link_ok && ok_ff && is_ack_ff;

   // status to the sequencer
   always_comb begin
      stat.kind       = kind_ff;
      stat.link_ok    = (link_ff >= LINK_W'(1)) && (link_ff <= LINK_W'(NUM_LINKS));
      stat.frame_ok   = ok_ff;
      stat.is_ack     = is_ack_ff;
      stat.seq_ok     = (seq_ff <= SEQ_W'(MAX_SEQUENCE));
      stat.route_bad  = (ol == '0) || (ol > LINK_W'(NUM_LINKS));
      stat.room       = (wc_ff[route_li] < WCNT_W'(MAX_SEQUENCE)) ||
                        (bc_ff[route_li] < BCNT_W'(SLOTS));
      stat.seq_is_fe  = (seq_ff == fe_cur);
      stat.seq_is_dup = (seq_ff == dup_seq);
      stat.dest_own   = (dest_ff == own_node_ff);
      stat.in_window  = seq_between(ae_ff[link_li], seq_ff, nts_ff[link_li]);
      stat.guard_ok   = (guard_ff < GUARD_W'(SLOTS));
      stat.refill_ok  = (wc_ff[link_li] < WCNT_W'(MAX_SEQUENCE)) && (bc_ff[link_li] != '0);
      stat.out_free   = !rsp_valid_ff || !rsp_stall;
      stat.drain_done = (drain_idx_ff == res_cnt_ff);
   end

   // every link has window room and an empty overflow queue
   always_comb begin
      links_clear = 1'b1;
      for (int i = 0; i < NUM_LINKS; i++) begin
         if (bc_ff[i] != '0 || wc_ff[i] >= WCNT_W'(MAX_SEQUENCE)) begin
            links_clear = 1'b0;
         end
      end
   end

   // step logic
   always_comb begin
      nts_in      = nts_ff;
      ae_in       = ae_ff;
      fe_in       = fe_ff;
      wc_in       = wc_ff;
      hd_in       = hd_ff;
      tl_in       = tl_ff;
      bc_in       = bc_ff;
      mask_in     = mask_ff;
      guard_in    = guard_ff;
      chk_in      = chk_ff;
      chk_link_in = chk_link_ff;
      emit_en     = 1'b0;
      e_act       = ACT_NONE;
      e_link      = '0;
      e_seq       = '0;
      e_src       = '0;
      e_dest      = '0;
      e_tag       = '0;
      win_we      = 1'b0;
      win_waddr   = {route_li, nts_ff[route_li]};
      win_wdata   = item_entry;
      buf_we      = 1'b0;
      buf_waddr   = {route_li, tl_ff[route_li]};
      buf_wdata   = item_entry;
      win_re      = 1'b0;
      win_raddr   = {link_li, seq_ff};
      buf_re      = 1'b0;
      buf_raddr   = {link_li, hd_ff[link_li]};
      unique case (cmd.op)
         OP_LOAD: begin
            guard_in = '0;
            chk_in   = 1'b0;
         end
         OP_DROP_BAD: begin
            emit_en = 1'b1;
            e_act   = ACT_DROP;
            e_src   = src_ff;
            e_dest  = dest_ff;
            e_tag   = tag_ff;
         end
         OP_DROP_FULL: begin
            emit_en     = 1'b1;
            e_act       = ACT_DROP;
            e_link      = ol;
            e_src       = src_ff;
            e_dest      = dest_ff;
            e_tag       = tag_ff;
            chk_in      = 1'b1;
            chk_link_in = ol;
         end
         OP_ENQ: begin
            chk_in      = 1'b1;
            chk_link_in = ol;
            if (wc_ff[route_li] < WCNT_W'(MAX_SEQUENCE)) begin
               win_we            = 1'b1;
               wc_in[route_li]   = wc_ff[route_li] + WCNT_W'(1);
               nts_in[route_li]  = seq_inc(nts_ff[route_li]);
               emit_en           = 1'b1;
               e_act             = ACT_SEND;
               e_link            = ol;
               e_seq             = nts_ff[route_li];
               e_src             = src_ff;
               e_dest            = dest_ff;
               e_tag             = tag_ff;
            end else begin
               buf_we          = 1'b1;
               bc_in[route_li] = bc_ff[route_li] + BCNT_W'(1);
               tl_in[route_li] = seq_inc(tl_ff[route_li]);
            end
         end
         OP_DATA_ACK: begin
            emit_en        = 1'b1;
            e_act          = ACT_ACK;
            e_link         = link_ff;
            e_seq          = seq_ff;
            fe_in[link_li] = seq_inc(fe_cur);
         end
         OP_DELIVER: begin
            emit_en = 1'b1;
            e_act   = ACT_DELIVER;
            e_link  = link_ff;
            e_seq   = seq_ff;
            e_src   = src_ff;
            e_dest  = dest_ff;
            e_tag   = tag_ff;
         end
         OP_DUP_ACK: begin
            emit_en = 1'b1;
            e_act   = ACT_ACK;
            e_link  = link_ff;
            e_seq   = seq_ff;
         end
         OP_TO_READ: begin
            win_re = 1'b1;
         end
         OP_TO_EMIT: begin
            emit_en = 1'b1;
            e_act   = ACT_SEND;
            e_link  = link_ff;
            e_seq   = seq_ff;
            {e_src, e_dest, e_tag} = win_rdata_ff;
         end
         OP_ACK_OUT: begin
            emit_en = 1'b1;
            e_act   = ACT_OUTSIDE;
            e_link  = link_ff;
            e_seq   = seq_ff;
         end
         OP_ACK_STEP: begin
            emit_en        = 1'b1;
            e_act          = ACT_STOP;
            e_link         = link_ff;
            e_seq          = ae_ff[link_li];
            ae_in[link_li] = seq_inc(ae_ff[link_li]);
            guard_in       = guard_ff + GUARD_W'(1);
            if (wc_ff[link_li] != '0) begin
               wc_in[link_li] = wc_ff[link_li] - WCNT_W'(1);
            end
         end
         OP_REF_READ: begin
            buf_re         = 1'b1;
            hd_in[link_li] = seq_inc(hd_ff[link_li]);
            bc_in[link_li] = bc_ff[link_li] - BCNT_W'(1);
         end
         OP_REF_WRITE: begin
            win_we          = 1'b1;
            win_waddr       = {link_li, nts_ff[link_li]};
            win_wdata       = buf_rdata_ff;
            wc_in[link_li]  = wc_ff[link_li] + WCNT_W'(1);
            nts_in[link_li] = seq_inc(nts_ff[link_li]);
            emit_en         = 1'b1;
            e_act           = ACT_SEND;
            e_link          = link_ff;
            e_seq           = nts_ff[link_li];
            {e_src, e_dest, e_tag} = buf_rdata_ff;
         end
         OP_FINISH: begin
            // full window on the target link closes its destinations
            if (chk_ff && wc_ff[chk_li] >= WCNT_W'(MAX_SEQUENCE)) begin
               for (int i = 0; i < NODE_COUNT; i++) begin
                  if (route_map_ff[3*i +: 3] == chk_link_ff) begin
                     mask_in[i] = 1'b0;
                  end
               end
            end
            if (ack_item && links_clear) begin
               mask_in = ALL_NODES;
            end
            // an item with no action still reports once
            if (res_cnt_ff == '0) begin
               emit_en = 1'b1;
            end
         end
         OP_NONE, OP_DRAIN_READ, OP_DRAIN_LOAD: begin
         end
         default: begin
         end
      endcase
   end

   assign res_cnt_in = (cmd.op == OP_LOAD) ? '0 :
                       (emit_en && res_cnt_ff < RES_CNT_W'(RESULT_CAP)) ?
                       res_cnt_ff + RES_CNT_W'(1) : res_cnt_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_LINKS; i++) begin
            nts_ff[i] <= '0;
            ae_ff[i]  <= '0;
            fe_ff[i]  <= '0;
            wc_ff[i]  <= '0;
            hd_ff[i]  <= '0;
            tl_ff[i]  <= '0;
            bc_ff[i]  <= '0;
         end
         mask_ff      <= ALL_NODES;
         guard_ff     <= '0;
         chk_ff       <= 1'b0;
         res_cnt_ff   <= '0;
         drain_idx_ff <= '0;
         rsp_valid_ff <= 1'b0;
         own_node_ff  <= '0;
         route_map_ff <= '0;
      end else begin
         nts_ff     <= nts_in;
         ae_ff      <= ae_in;
         fe_ff      <= fe_in;
         wc_ff      <= wc_in;
         hd_ff      <= hd_in;
         tl_ff      <= tl_in;
         bc_ff      <= bc_in;
         mask_ff    <= mask_in;
         guard_ff   <= guard_in;
         chk_ff     <= chk_in;
         res_cnt_ff <= res_cnt_in;
         if (cmd.op == OP_LOAD) begin
            drain_idx_ff <= '0;
         end else if (cmd.op == OP_DRAIN_LOAD) begin
            drain_idx_ff <= drain_idx_ff + RES_CNT_W'(1);
         end
         if (cmd.op == OP_DRAIN_LOAD) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         // configuration writes
         if (psel && penable && pwrite) begin
            if (paddr[2] == ADDR_OWN_NODE) begin
               own_node_ff <= pwdata[NODE_W-1:0];
            end else begin
               route_map_ff <= pwdata[3*NODE_COUNT-1:0];
            end
         end
      end
   end

   // item and payload registers
   always_ff @(posedge clock) begin
      chk_link_ff <= chk_link_in;
      if (cmd.op == OP_LOAD) begin
         kind_ff   <= req_kind;
         link_ff   <= req_link;
         is_ack_ff <= req_is_ack;
         ok_ff     <= req_check_ok;
         seq_ff    <= req_seq;
         src_ff    <= (req_kind == KIND_SEND) ? own_node_ff : req_src_node;
         dest_ff   <= req_dest_node;
         tag_ff    <= req_payload_tag[TAG_WIDTH-1:0];
      end
      if (cmd.op == OP_DRAIN_LOAD) begin
         rsp_rec_ff  <= res_rdata_ff;
         rsp_mask_ff <= mask_ff;
         rsp_last_ff <= (drain_idx_ff + RES_CNT_W'(1) == res_cnt_ff);
      end
   end

   // window store
   always_ff @(posedge clock) begin
      if (win_we) begin
         win_mem_ff[win_waddr] <= win_wdata;
      end
      if (win_re) begin
         win_rdata_ff <= win_mem_ff[win_raddr];
      end
   end

   // overflow store
   always_ff @(posedge clock) begin
      if (buf_we) begin
         buf_mem_ff[buf_waddr] <= buf_wdata;
      end
      if (buf_re) begin
         buf_rdata_ff <= buf_mem_ff[buf_raddr];
      end
   end

   // result buffer
   always_ff @(posedge clock) begin
      if (emit_en && res_cnt_ff < RES_CNT_W'(RESULT_CAP)) begin
         res_mem_ff[res_cnt_ff[RES_IDX_W-1:0]] <= {e_act, e_link, e_seq, e_src, e_dest, e_tag};
      end
      if (cmd.op == OP_DRAIN_READ) begin
         res_rdata_ff <= res_mem_ff[drain_idx_ff[RES_IDX_W-1:0]];
      end
   end

   // result ports
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_action      = rsp_rec_ff[R_ACT +: 3];
   assign rsp_out_link    = rsp_rec_ff[R_LINK +: LINK_W];
   assign rsp_out_seq     = rsp_rec_ff[R_SEQ +: SEQ_W];
   assign rsp_out_src     = rsp_rec_ff[R_SRC +: NODE_W];
   assign rsp_out_dest    = rsp_rec_ff[R_DEST +: NODE_W];
   assign rsp_out_tag     = PORT_TAG_W'(rsp_rec_ff[TAG_WIDTH-1:0]);
   assign rsp_dest_enable = rsp_mask_ff;
   assign rsp_last        = rsp_last_ff;

   // register read-back
   assign prdata = (paddr[2] == ADDR_OWN_NODE) ? CSR_DATA_W'(own_node_ff) :
                                                 CSR_DATA_W'(route_map_ff);

endmodule

// ===== hdl/go_back_n_link_engine_core.sv =====
// ----------------------------------------------------------------------------
// go_back_n_link_engine_core
// Go-back-N link engine: sends, arriving frames and timeouts per link.
// ----------------------------------------------------------------------------
// One item is taken at a time, and the input stays stalled until all of its
// results have gone to the output register. A send, a dropped frame, an
// ignored frame or an unused kind passes through accept, decode and finish.
// A delivery, a forward or a timeout adds its own step before finish. An ACK
// walks the acknowledged slots one at a time and then moves frames one at a
// time from the overflow queue into the window, with a read and a write
// each; both walks are bounded by the window size. Reading out then takes a
// read and a load per result (1 to 16 results) and waits while the result
// side stalls. The sequencer steps one entry at a time through the window
// and overflow stores. Results stay in the output register while the next
// item is accepted. All results of one item carry the destination enable
// mask as it stands after that item.
`timescale 1ns / 1ps
`include "go_back_n_link_engine_core_macros.svh"
module go_back_n_link_engine_core
   import gbn_pkg::*;
#(
   parameter int NUM_LINKS = NUM_LINKS_DEF,
   parameter int TAG_WIDTH = TAG_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            req_kind,
   input  logic [LINK_W-1:0]     req_link,
   input  logic                  req_is_ack,
   input  logic                  req_check_ok,
   input  logic [SEQ_W-1:0]      req_seq,
   input  logic [NODE_W-1:0]     req_src_node,
   input  logic [NODE_W-1:0]     req_dest_node,
   input  logic [PORT_TAG_W-1:0] req_payload_tag,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [2:0]            rsp_action,
   output logic [LINK_W-1:0]     rsp_out_link,
   output logic [SEQ_W-1:0]      rsp_out_seq,
   output logic [NODE_W-1:0]     rsp_out_src,
   output logic [NODE_W-1:0]     rsp_out_dest,
   output logic [PORT_TAG_W-1:0] rsp_out_tag,
   output logic [MASK_W-1:0]     rsp_dest_enable,
   output logic                  rsp_last,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   cmd_type    cmd;
   status_type stat;

   assign pready = 1'b1;

   // sequencer
   gbn_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // state and stores
   gbn_datapath #(
      .NUM_LINKS (NUM_LINKS),
      .TAG_WIDTH (TAG_WIDTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_kind        (req_kind),
      .req_link        (req_link),
      .req_is_ack      (req_is_ack),
      .req_check_ok    (req_check_ok),
      .req_seq         (req_seq),
      .req_src_node    (req_src_node),
      .req_dest_node   (req_dest_node),
      .req_payload_tag (req_payload_tag),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_action      (rsp_action),
      .rsp_out_link    (rsp_out_link),
      .rsp_out_seq     (rsp_out_seq),
      .rsp_out_src     (rsp_out_src),
      .rsp_out_dest    (rsp_out_dest),
      .rsp_out_tag     (rsp_out_tag),
      .rsp_dest_enable (rsp_dest_enable),
      .rsp_last        (rsp_last),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata)
   );

   // an accepted item closes the input until it is drained
   `GBN_ASSERT_NXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)
   // a drain load always presents a result
   `GBN_ASSERT_NXT(a_drain_shows_item, clock, reset, cmd.op == OP_DRAIN_LOAD, rsp_valid)
   // an enqueue only happens when the target link has room
   `GBN_ASSERT_IMP(a_enq_has_room, clock, reset, cmd.op == OP_ENQ, stat.room)

endmodule
